// ----- sv/lat_long_to_local_position_macros.svh -----
// Assertion macros for the local position block
`ifndef LAT_LONG_TO_LOCAL_POSITION_MACROS_SVH
`define LAT_LONG_TO_LOCAL_POSITION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LLP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
`define LLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define LLP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/llp_pkg.sv -----
package llp_pkg;
	localparam int ITERS = 28;
	localparam int LAT_W = 30;
	localparam int LON_W = 31;
	localparam int RAD_W = 23;
	localparam int OUT_W = 30;
	localparam int CW = 34;

	localparam logic [1:0] REG_ORIGIN_LAT = 2'd0;
	localparam logic [1:0] REG_ORIGIN_LON = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	localparam logic signed [CW-1:0] ONE_Q30 = CW'(64'sd1073741824);
	localparam logic signed [CW-1:0] HALF_PI_Q30 = CW'(64'sd1686629713);
	localparam logic signed [CW-1:0] GAIN_INV_Q30 = CW'(64'sd652032874);
	localparam logic [32:0] DEG180_Q23 = 33'd1509949440;
	localparam logic [32:0] DEG90_Q23 = 33'd754974720;
	localparam logic [34:0] DEG_TO_RAD = 35'd19190098069;
	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(6371000);

	typedef enum logic {MODE_ROT, MODE_VEC} cmode_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cvec_t;

	function automatic logic signed [CW-1:0] atan_of(input logic [4:0] i);
		logic signed [CW-1:0] r;
		unique case (i)
			5'd0: r = CW'(64'sd843314856);
			5'd1: r = CW'(64'sd497837829);
			5'd2: r = CW'(64'sd263043836);
			5'd3: r = CW'(64'sd133525158);
			5'd4: r = CW'(64'sd67021686);
			5'd5: r = CW'(64'sd33543515);
			5'd6: r = CW'(64'sd16775850);
			5'd7: r = CW'(64'sd8388437);
			5'd8: r = CW'(64'sd4194282);
			5'd9: r = CW'(64'sd2097149);
			default: r = (CW'(64'sd1) <<< (5'd30 - i)) - CW'(64'sd1);
		endcase
		return r;
	endfunction

	function automatic logic [32:0] fold_q23(input logic signed [32:0] a);
		logic signed [33:0] m;
		logic signed [33:0] d180;
		logic [32:0] r;
		d180 = signed'(34'(DEG180_Q23));
		m = 34'(a);
		if (m >= d180) m = m - d180;
		if (m >= d180) m = m - d180;
		if (m < 0) m = m + d180;
		if (m < 0) m = m + d180;
		r = m[32:0];
		if (r > DEG90_Q23) r = DEG180_Q23 - r;
		return r;
	endfunction
endpackage

// ----- sv/llp_cell.sv -----
module llp_cell #(
	parameter logic [4:0] IDX = 5'd0
) (
	input  logic        clk,
	input  llp_pkg::cmode_t mode,
	input  llp_pkg::cvec_t  a,
	output llp_pkg::cvec_t  b
);
	import llp_pkg::*;
	logic signed [CW-1:0] dx, dy;
	logic pos;
	assign dx = a.y >>> IDX;
	assign dy = a.x >>> IDX;
	assign pos = (mode == MODE_ROT) ? (a.z >= 0) : !(a.y > 0);
	always_ff @(posedge clk) begin
		if (pos) begin
			b.x <= a.x - dx;
			b.y <= a.y + dy;
			b.z <= a.z - atan_of(IDX);
		end else begin
			b.x <= a.x + dx;
			b.y <= a.y - dy;
			b.z <= a.z + atan_of(IDX);
		end
	end
endmodule

// ----- sv/llp_chain.sv -----
module llp_chain (
	input  logic clk,
	input  llp_pkg::cmode_t mode,
	input  llp_pkg::cvec_t  din,
	output llp_pkg::cvec_t  dout
);
	import llp_pkg::*;
	cvec_t link [0:ITERS];
	assign link[0] = din;
	for (genvar g = 0; g < ITERS; g++) begin : g_cell
		llp_cell #(.IDX(5'(g))) u_cell (.clk(clk), .mode(mode), .a(link[g]), .b(link[g+1]));
	end
	assign dout = link[ITERS];
endmodule

// ----- sv/llp_isqrt.sv -----
module llp_isqrt (
	input  logic        clk,
	input  logic [61:0] din,
	output logic [30:0] root
);
	import llp_pkg::*;
	logic [61:0] rem [0:31];
	logic [30:0] acc [0:31];
	assign rem[0] = din;
	assign acc[0] = '0;
	for (genvar g = 0; g < 31; g++) begin : g_step
		logic [63:0] trial;
		logic [63:0] rshift;
		assign trial = {acc[g], 2'b01} << (2 * (30 - g));
		assign rshift = 64'(rem[g]);
		always_ff @(posedge clk) begin
			if (rshift >= trial) begin
				rem[g+1] <= 62'(rshift - trial);
				acc[g+1] <= {acc[g][29:0], 1'b1};
			end else begin
				rem[g+1] <= rem[g];
				acc[g+1] <= {acc[g][29:0], 1'b0};
			end
		end
	end
	assign root = acc[31];
endmodule

// ----- sv/lat_long_to_local_position.sv -----
// Local north/east offsets from a configured origin, one point per request.
// Input channel: a request is taken at a clock edge with start high and busy low;
// busy stays low, so a point may enter in every cycle.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, ready always high;
// write only while no request is in flight.
// Output: done pulses for one cycle with north_offset and east_offset. The result sits
// in register stage LAT = 95, together with done; the stages are 3 fold and radian
// stages, 28 CORDIC cells (sine and cosine chains side by side), 3 product and square
// stages, a 31-step square root pipeline, 28 arcsine cells and 2 distance stages.
// Throughput is one point per cycle; results leave in request order.
// The receiver cannot stall, so no result is ever held back.
// Reset clears all pipeline valid bits and sets origin 0,0 and radius 6371000.
module lat_long_to_local_position (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [llp_pkg::LAT_W-1:0] point_latitude,
	input  logic signed [llp_pkg::LON_W-1:0] point_longitude,
	output logic done,
	output logic signed [llp_pkg::OUT_W-1:0] north_offset,
	output logic signed [llp_pkg::OUT_W-1:0] east_offset,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import llp_pkg::*;
`include "lat_long_to_local_position_macros.svh"
	localparam int LAT = 3 + ITERS + 3 + 31 + ITERS + 2;
	logic signed [LAT_W-1:0] olat_q;
	logic signed [LON_W-1:0] olon_q;
	logic [RAD_W-1:0] rad_q;
	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olat_q <= '0;
			olon_q <= '0;
			rad_q <= RADIUS_RESET;
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_ORIGIN_LAT: olat_q <= cfg_data[LAT_W-1:0];
					REG_ORIGIN_LON: olon_q <= cfg_data[LON_W-1:0];
					REG_RADIUS: rad_q <= cfg_data[RAD_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// stage 1: differences and twice the origin latitude folded to [0,90] degrees
	logic [32:0] mlat_s1, mlon_s1, mor_s1;
	logic neg_n_s1, neg_e_s1;
	always_ff @(posedge clk) begin
		mlat_s1 <= fold_q23(33'(point_latitude) - 33'(olat_q));
		mlon_s1 <= fold_q23(33'(point_longitude) - 33'(olon_q));
		mor_s1 <= fold_q23(33'(olat_q) <<< 1);
		neg_n_s1 <= point_latitude < olat_q;
		neg_e_s1 <= point_longitude < olon_q;
	end
	// stage 2,3: radians, product split into two halves
	logic [63:0] plo_lat_s2, plo_lon_s2, plo_or_s2;
	logic [63:0] phi_lat_s2, phi_lon_s2, phi_or_s2;
	always_ff @(posedge clk) begin
		plo_lat_s2 <= 64'(mlat_s1[16:0]) * 64'(DEG_TO_RAD);
		phi_lat_s2 <= 64'(mlat_s1[32:17]) * 64'(DEG_TO_RAD);
		plo_lon_s2 <= 64'(mlon_s1[16:0]) * 64'(DEG_TO_RAD);
		phi_lon_s2 <= 64'(mlon_s1[32:17]) * 64'(DEG_TO_RAD);
		plo_or_s2 <= 64'(mor_s1[16:0]) * 64'(DEG_TO_RAD);
		phi_or_s2 <= 64'(mor_s1[32:17]) * 64'(DEG_TO_RAD);
	end
	function automatic logic [30:0] to_rad(input logic [63:0] lo, input logic [63:0] hi);
		logic [69:0] s;
		s = 70'(lo) + (70'(hi) << 17) + 70'(64'h1_0000_0000);
		return s[63:33];
	endfunction
	logic [30:0] rlat_s3, rlon_s3, ror_s3;
	always_ff @(posedge clk) begin
		rlat_s3 <= to_rad(plo_lat_s2, phi_lat_s2);
		rlon_s3 <= to_rad(plo_lon_s2, phi_lon_s2);
		ror_s3 <= to_rad(plo_or_s2, phi_or_s2);
	end

	cvec_t in_lon, in_or, out_lon, out_or;
	assign in_lon = '{x: GAIN_INV_Q30, y: '0, z: CW'(rlon_s3)};
	assign in_or = '{x: GAIN_INV_Q30, y: '0, z: CW'(ror_s3)};
	llp_chain u_sin (.clk(clk), .mode(MODE_ROT), .din(in_lon), .dout(out_lon));
	llp_chain u_cos (.clk(clk), .mode(MODE_ROT), .din(in_or), .dout(out_or));

	// clamp, root product, then clamp again
	logic [30:0] root_s5;
	logic [30:0] sa_s4, sb_s4;
	always_ff @(posedge clk) begin
		sa_s4 <= out_lon.y < 0 ? '0 : (out_lon.y >= ONE_Q30 ? 31'h40000000 : 31'(out_lon.y));
		sb_s4 <= out_or.x < 0 ? '0 : (out_or.x >= ONE_Q30 ? 31'h40000000 : 31'(out_or.x));
	end
	logic [61:0] rprod;
	assign rprod = 62'(sa_s4) * 62'(sb_s4);
	always_ff @(posedge clk) begin
		root_s5 <= (rprod[61:30] > 32'h40000000) ? 31'h40000000 : 31'(rprod[61:30]);
	end

	logic [61:0] sq_s6;
	logic [30:0] root_d [0:31];
	always_ff @(posedge clk) begin
		sq_s6 <= 62'(62'h1000_0000_0000_0000 - 62'(root_s5) * 62'(root_s5));
		root_d[0] <= root_s5;
		for (int k = 1; k < 32; k++) root_d[k] <= root_d[k-1];
	end
	logic [30:0] xr;
	llp_isqrt u_sqrt (.clk(clk), .din(sq_s6), .root(xr));

	cvec_t in_as, out_as;
	assign in_as = '{x: CW'(xr), y: CW'(root_d[31]), z: '0};
	llp_chain u_asin (.clk(clk), .mode(MODE_VEC), .din(in_as), .dout(out_as));

	// align north path, the sign flags and the zero-root flag
	localparam int DN = LAT - 5;
	logic [30:0] rlat_d [0:DN-1];
	logic [DN+1:0] nn_d;
	logic [DN+1:0] ne_d;
	logic [ITERS-1:0] z0_d;
	always_ff @(posedge clk) begin
		rlat_d[0] <= rlat_s3;
		for (int k = 1; k < DN; k++) rlat_d[k] <= rlat_d[k-1];
		ne_d <= {ne_d[DN:0], neg_e_s1};
		nn_d <= {nn_d[DN:0], neg_n_s1};
		z0_d <= {z0_d[ITERS-2:0], root_d[31] == '0};
	end
	logic signed [CW-1:0] az;
	assign az = out_as.z < 0 ? '0 : (out_as.z > HALF_PI_Q30 ? HALF_PI_Q30 : out_as.z);
	logic [30:0] ea_sn, na_sn;
	logic ngn, nge;
	always_ff @(posedge clk) begin
		ea_sn <= z0_d[ITERS-1] ? '0 : 31'(az);
		na_sn <= rlat_d[DN-1];
		ngn <= nn_d[DN+1];
		nge <= ne_d[DN+1];
	end
	logic [53:0] dn_c, de_c;
	assign dn_c = 54'(rad_q) * 54'(na_sn) + 54'(25'h1000000);
	assign de_c = 54'(rad_q) * 54'(ea_sn) + 54'(25'h1000000);
	always_ff @(posedge clk) begin
		north_offset <= ngn ? -OUT_W'(dn_c >> 25) : OUT_W'(dn_c >> 25);
		east_offset <= nge ? -OUT_W'(de_c >> 25) : OUT_W'(de_c >> 25);
	end
	assign done = vld_q[LAT-1];

	`LLP_ASSERT_IMPL(a_never_busy, clk, arst_n, 1'b1, !busy)
	`LLP_ASSERT_NEXT(a_done_follows, clk, arst_n, vld_q[LAT-2], done)
	`LLP_ASSERT_IMPL(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)
endmodule
